// ===== rtl/cfr_pkg.sv =====
// Shared types and constants of the command frame receiver.
// Used by cfr_front, cfr_queue, cfr_back and command_frame_receiver.
package cfr_pkg;

    localparam int FRAME_BYTES = 64;
    localparam int ADDR_W      = 6;
    localparam int LEN_W       = 7;
    localparam int CNT_W       = 16;
    localparam int CMD_BYTES   = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_DATA_W  = 104;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_ID    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SETTING_ID    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_TIMEOUT  = 3'd6;

    // Input kinds
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Job kinds in the queue
    localparam logic JOB_TICK  = 1'b0;
    localparam logic JOB_FRAME = 1'b1;

    // Event codes
    localparam logic [1:0] EV_GOOD = 2'd0;
    localparam logic [1:0] EV_BAD  = 2'd1;
    localparam logic [1:0] EV_LOST = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [7:0]       header_first;
        logic [7:0]       header_second;
        logic [5:0]       min_length;
        logic [6:0]       max_length;
        logic [3:0]       control_id;
        logic [3:0]       setting_id;
        logic [CNT_W-1:0] link_timeout;
    } cfg_t;

    typedef struct packed {
        logic             kind;
        logic             good;
        logic [7:0]       seq;
        logic [LEN_W-1:0] len;
    } job_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

endpackage

// ===== rtl/cfr_front.sv =====
// Front part: header hunt, length check, frame byte capture and running sum.
// Depends on cfr_pkg; feeds cfr_queue and the frame store in cfr_back.
module cfr_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfr_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    input  logic                  in_action,
    input  logic [7:0]            in_byte,
    output logic                  in_ready,
    input  logic                  q_full,
    output logic                  push,
    output cfr_pkg::job_t         push_job,
    output cfr_pkg::store_wr_t    store_wr,
    input  logic                  frame_done
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_HDR2 = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    logic [1:0]                phase_reg, phase_next;
    logic [cfr_pkg::LEN_W-1:0] len_reg, len_next;
    logic [cfr_pkg::LEN_W-1:0] taken_reg, taken_next;
    logic [7:0]                ck1_reg, ck1_next, ck2_reg, ck2_next;
    logic [7:0]                last_reg, last_next, seq_reg, seq_next;
    logic                      busy_reg, busy_next;
    logic                      accept;
    logic [7:0]                ck1_add;
    logic [cfr_pkg::LEN_W:0]   taken_p3;
    logic                      len_ok;

    // Hold off while the queue is full or a finished frame still sits in the store
    assign in_ready = !q_full && !busy_reg;
    assign accept   = in_valid && in_ready;
    assign ck1_add  = ck1_reg + in_byte;
    assign taken_p3 = {1'b0, taken_reg} + (cfr_pkg::LEN_W+1)'(3);
    assign len_ok   = (in_byte > {2'b00, cfg.min_length}) && (in_byte < {1'b0, cfg.max_length})
                      && (in_byte <= 8'(cfr_pkg::FRAME_BYTES));

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        taken_next = taken_reg;
        ck1_next   = ck1_reg;
        ck2_next   = ck2_reg;
        last_next  = last_reg;
        seq_next   = seq_reg;
        busy_next  = busy_reg;
        push       = 1'b0;
        push_job   = '0;
        store_wr   = '0;
        if (frame_done)
        begin
            busy_next = 1'b0;
        end
        if (accept && in_action == cfr_pkg::ACT_TICK)
        begin
            push          = 1'b1;
            push_job.kind = cfr_pkg::JOB_TICK;
        end
        else if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (in_byte == cfg.header_first)
                    begin
                        phase_next = PH_HDR2;
                    end
                end
                PH_HDR2:
                begin
                    phase_next = (in_byte == cfg.header_second) ? PH_LEN : PH_HUNT;
                end
                PH_LEN:
                begin
                    if (len_ok)
                    begin
                        phase_next = PH_DATA;
                        len_next   = in_byte[cfr_pkg::LEN_W-1:0];
                        taken_next = '0;
                        last_next  = in_byte;
                        // Length byte is summed when L is at least two
                        ck1_next   = (in_byte >= 8'd2) ? in_byte : 8'd0;
                        ck2_next   = (in_byte >= 8'd2) ? in_byte : 8'd0;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    store_wr.we   = 1'b1;
                    store_wr.addr = taken_reg[cfr_pkg::ADDR_W-1:0];
                    store_wr.data = in_byte;
                    if (taken_reg == '0)
                    begin
                        seq_next = in_byte;
                    end
                    if (taken_p3 <= {1'b0, len_reg})
                    begin
                        ck1_next = ck1_add;
                        ck2_next = ck2_reg + ck1_add;
                    end
                    last_next  = in_byte;
                    taken_next = taken_reg + 1'b1;
                    if (taken_next >= len_reg)
                    begin
                        phase_next    = PH_HUNT;
                        busy_next     = 1'b1;
                        push          = 1'b1;
                        push_job.kind = cfr_pkg::JOB_FRAME;
                        push_job.len  = len_reg;
                        push_job.seq  = (taken_reg == '0) ? in_byte : seq_reg;
                        push_job.good = ({last_reg, in_byte} == {ck1_reg, ck2_reg});
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            len_reg   <= '0;
            taken_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            taken_reg <= taken_next;
            busy_reg  <= busy_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ck1_reg  <= ck1_next;
        ck2_reg  <= ck2_next;
        last_reg <= last_next;
        seq_reg  <= seq_next;
    end

endmodule

// ===== rtl/cfr_queue.sv =====
// Two-entry job queue between the front and back parts.
// Depends on cfr_pkg.
module cfr_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cfr_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output cfr_pkg::job_t head_job
);

    cfr_pkg::job_t slot_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg, cnt_next;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_job   = slot_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !(pop && head_valid))
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && pop && head_valid)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop && head_valid)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/cfr_back.sv =====
// Back part: link watchdog, sequence check, record walk over the frame store,
// counters and the output register. Depends on cfr_pkg.
module cfr_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  cfr_pkg::cfg_t                    cfg,
    input  cfr_pkg::store_wr_t               store_wr,
    input  logic                             head_valid,
    input  cfr_pkg::job_t                    head_job,
    output logic                             pop,
    output logic                             frame_done,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       out_event,
    output logic [cfr_pkg::OUT_DATA_W-1:0]   out_data
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_HEAD_RD = 3'd1;
    localparam logic [2:0] S_HEAD    = 3'd2;
    localparam logic [2:0] S_DATA_RD = 3'd3;
    localparam logic [2:0] S_DATA    = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;

    logic [7:0]                 store_mem [cfr_pkg::FRAME_BYTES];
    logic [7:0]                 rd_data_reg;
    logic [cfr_pkg::ADDR_W-1:0] rd_addr;

    logic [2:0]                 state_reg, state_next;
    logic [cfr_pkg::LEN_W-1:0]  idx_reg, idx_next, flen_reg, flen_next;
    logic [4:0]                 rlen_reg, rlen_next;
    logic                       rctl_reg, rctl_next;
    logic [2:0]                 k_reg, k_next;
    logic [7:0]                 cmd_reg [cfr_pkg::CMD_BYTES];
    logic [7:0]                 cmd_next [cfr_pkg::CMD_BYTES];
    logic [6:0]                 mode_reg, mode_next;
    logic [cfr_pkg::CNT_W-1:0]  bad_reg, bad_next, seqc_reg, seqc_next;
    logic [cfr_pkg::CNT_W-1:0]  recc_reg, recc_next, idle_reg, idle_next;
    logic                       link_reg, link_next;
    logic [7:0]                 exp_reg, exp_next;
    logic [1:0]                 ev_reg, ev_next;
    logic                       serr_reg, serr_next, recon_reg, recon_next;
    logic                       ovalid_reg;
    logic [1:0]                 oev_reg;
    logic [cfr_pkg::OUT_DATA_W-1:0] odata_reg;

    logic                       out_free;
    logic [cfr_pkg::LEN_W-1:0]  idx_p1, idx_m1, pos, pos_m1;
    logic                       pos_in;
    logic [7:0]                 dval;
    logic [4:0]                 hlen;

    assign out_free = !ovalid_reg || out_ready;
    assign idx_p1   = idx_reg + 1'b1;
    assign idx_m1   = idx_reg - 1'b1;
    assign pos      = idx_p1 + {4'd0, k_reg};
    assign pos_m1   = idx_reg + {4'd0, k_reg};
    assign pos_in   = (pos <= flen_reg) && (pos <= cfr_pkg::LEN_W'(cfr_pkg::FRAME_BYTES));
    assign dval     = pos_in ? rd_data_reg : 8'd0;
    assign hlen     = (rd_data_reg[3:0] == 4'd0) ? 5'd16 : {1'b0, rd_data_reg[3:0]};
    assign rd_addr  = (state_reg == S_HEAD_RD) ? idx_m1[cfr_pkg::ADDR_W-1:0]
                                               : pos_m1[cfr_pkg::ADDR_W-1:0];

    // Frame store: written by the front, read by the record walk
    always_ff @(posedge clk)
    begin
        if (store_wr.we)
        begin
            store_mem[store_wr.addr] <= store_wr.data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        flen_next  = flen_reg;
        rlen_next  = rlen_reg;
        rctl_next  = rctl_reg;
        k_next     = k_reg;
        for (int i = 0; i < cfr_pkg::CMD_BYTES; i++)
        begin
            cmd_next[i] = cmd_reg[i];
        end
        mode_next  = mode_reg;
        bad_next   = bad_reg;
        seqc_next  = seqc_reg;
        recc_next  = recc_reg;
        idle_next  = idle_reg;
        link_next  = link_reg;
        exp_next   = exp_reg;
        ev_next    = ev_reg;
        serr_next  = serr_reg;
        recon_next = recon_reg;
        pop        = 1'b0;
        frame_done = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head_job.kind == cfr_pkg::JOB_TICK)
                    begin
                        // Age the link and flag the loss once
                        if (idle_reg != cfr_pkg::CNT_MAX)
                        begin
                            idle_next = idle_reg + 1'b1;
                        end
                        if (idle_next > cfg.link_timeout && link_reg)
                        begin
                            link_next  = 1'b0;
                            ev_next    = cfr_pkg::EV_LOST;
                            serr_next  = 1'b0;
                            recon_next = 1'b0;
                            state_next = S_EMIT;
                        end
                    end
                    else
                    begin
                        recon_next = !link_reg;
                        if (!link_reg && recc_reg != cfr_pkg::CNT_MAX)
                        begin
                            recc_next = recc_reg + 1'b1;
                        end
                        link_next = 1'b1;
                        idle_next = '0;
                        serr_next = (exp_reg != head_job.seq);
                        if (exp_reg != head_job.seq && seqc_reg != cfr_pkg::CNT_MAX)
                        begin
                            seqc_next = seqc_reg + 1'b1;
                        end
                        exp_next  = head_job.seq + 8'd1;
                        flen_next = head_job.len;
                        if (head_job.good)
                        begin
                            ev_next    = cfr_pkg::EV_GOOD;
                            idx_next   = cfr_pkg::LEN_W'(2);
                            state_next = S_HEAD_RD;
                        end
                        else
                        begin
                            ev_next = cfr_pkg::EV_BAD;
                            if (bad_reg != cfr_pkg::CNT_MAX)
                            begin
                                bad_next = bad_reg + 1'b1;
                            end
                            state_next = S_EMIT;
                        end
                    end
                end
            end
            S_HEAD_RD:
            begin
                state_next = (idx_p1 < flen_reg) ? S_HEAD : S_EMIT;
            end
            S_HEAD:
            begin
                rlen_next = hlen;
                k_next    = '0;
                if (rd_data_reg[7:4] == cfg.control_id)
                begin
                    rctl_next  = 1'b1;
                    state_next = S_DATA_RD;
                end
                else if (rd_data_reg[7:4] == cfg.setting_id)
                begin
                    rctl_next  = 1'b0;
                    state_next = S_DATA_RD;
                end
                else
                begin
                    idx_next   = idx_p1 + {2'd0, hlen};
                    state_next = S_HEAD_RD;
                end
            end
            S_DATA_RD:
            begin
                state_next = S_DATA;
            end
            S_DATA:
            begin
                if (rctl_reg)
                begin
                    cmd_next[k_reg] = dval;
                end
                else
                begin
                    mode_next = dval[7:1];
                end
                if (rctl_reg && k_reg != 3'(cfr_pkg::CMD_BYTES - 1))
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_DATA_RD;
                end
                else
                begin
                    idx_next   = idx_p1 + {2'd0, rlen_reg};
                    state_next = S_HEAD_RD;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    frame_done = (ev_reg != cfr_pkg::EV_LOST);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg[0] <= 8'd1;
            cmd_reg[1] <= 8'd0;
            cmd_reg[2] <= 8'd0;
            cmd_reg[3] <= 8'd1;
            cmd_reg[4] <= 8'd1;
            mode_reg   <= '0;
            bad_reg    <= '0;
            seqc_reg   <= '0;
            recc_reg   <= '0;
            idle_reg   <= '0;
            link_reg   <= 1'b0;
            exp_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            for (int i = 0; i < cfr_pkg::CMD_BYTES; i++)
            begin
                cmd_reg[i] <= cmd_next[i];
            end
            mode_reg <= mode_next;
            bad_reg  <= bad_next;
            seqc_reg <= seqc_next;
            recc_reg <= recc_next;
            idle_reg <= idle_next;
            link_reg <= link_next;
            exp_reg  <= exp_next;
            // Load the output register when the result is ready, drop on take
            if (state_reg == S_EMIT && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        flen_reg  <= flen_next;
        rlen_reg  <= rlen_next;
        rctl_reg  <= rctl_next;
        k_reg     <= k_next;
        ev_reg    <= ev_next;
        serr_reg  <= serr_next;
        recon_reg <= recon_next;
        if (state_reg == S_EMIT && out_free)
        begin
            oev_reg   <= ev_reg;
            odata_reg <= {7'd0, recc_reg, seqc_reg, bad_reg, mode_reg,
                          cmd_reg[4], cmd_reg[3], cmd_reg[2], cmd_reg[1], cmd_reg[0],
                          recon_reg, serr_reg};
        end
    end

    assign out_valid = ovalid_reg;
    assign out_event = oev_reg;
    assign out_data  = odata_reg;

endmodule

// ===== rtl/command_frame_receiver.sv =====
// Top level of the command frame receiver: configuration registers and the
// front / queue / back chain. Depends on cfr_pkg, cfr_front, cfr_queue, cfr_back.
//
// Channel   Direction  Beat contents
// s_axis    in         tuser: action; tdata: byte_value
// m_axis    out        tuser: event_res; tdata: flags, commands, mode bits, counters
// cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// A byte or tick beat is taken while s_tready is high. The last byte of a good
// frame starts a record walk over the frame store; each header or data byte is
// read through its single read port in a read state and a use state. A control
// record always reads five data bytes. New beats are held off while that frame
// is walked. Reset clears control state; the frame store has no reset. The output
// register holds a result until m_tready; a second result then waits in the back,
// which stalls the front through the queue.
module command_frame_receiver
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] byte_value
    input  logic                               s_tuser,   // [0] action
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] sequence_error, [1] reconnected, [9:2] drive_mode, [17:10] velocity,
    // [25:18] rotation, [33:26] accelerate, [41:34] gear, [48:42] report_mode_bits,
    // [64:49] bad_frame_count, [80:65] sequence_error_count,
    // [96:81] reconnect_count, [103:97] zero
    output logic [cfr_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [1:0]                         m_tuser,   // [1:0] event_res
    input  logic                               cfg_we,
    input  logic [cfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cfr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    cfr_pkg::cfg_t      cfg_reg;
    cfr_pkg::job_t      push_job, head_job;
    cfr_pkg::store_wr_t store_wr;
    logic               push, q_full, pop, head_valid, frame_done;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first  <= 8'd170;
            cfg_reg.header_second <= 8'd85;
            cfg_reg.min_length    <= 6'd3;
            cfg_reg.max_length    <= 7'd64;
            cfg_reg.control_id    <= 4'd1;
            cfg_reg.setting_id    <= 4'd2;
            cfg_reg.link_timeout  <= 16'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cfr_pkg::REG_HEADER_FIRST:  cfg_reg.header_first  <= cfg_data[7:0];
                cfr_pkg::REG_HEADER_SECOND: cfg_reg.header_second <= cfg_data[7:0];
                cfr_pkg::REG_MIN_LENGTH:    cfg_reg.min_length    <= cfg_data[5:0];
                cfr_pkg::REG_MAX_LENGTH:    cfg_reg.max_length    <= cfg_data[6:0];
                cfr_pkg::REG_CONTROL_ID:    cfg_reg.control_id    <= cfg_data[3:0];
                cfr_pkg::REG_SETTING_ID:    cfg_reg.setting_id    <= cfg_data[3:0];
                cfr_pkg::REG_LINK_TIMEOUT:  cfg_reg.link_timeout  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    cfr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_action  (s_tuser),
        .in_byte    (s_tdata),
        .in_ready   (s_tready),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job),
        .store_wr   (store_wr),
        .frame_done (frame_done)
    );

    cfr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    cfr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .store_wr   (store_wr),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .frame_done (frame_done),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_event  (m_tuser),
        .out_data   (m_tdata)
    );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for command_frame_receiver: byte and tick beats in,
// event beats out, compared with an in-bench frame predictor. Depends on cfr_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 200;

    typedef struct packed {
        logic [1:0]  ev;
        logic        seq_err;
        logic        recon;
        logic [39:0] cmd;      // drive_mode in [7:0] up to gear in [39:32]
        logic [6:0]  mode;
        logic [15:0] bad_cnt;
        logic [15:0] seq_cnt;
        logic [15:0] rec_cnt;
    } event_t;

    typedef struct {
        logic act;
        logic [7:0] val;
        int ev;            // typed event code, or -1 when left to the predictor
    } row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [7:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [cfr_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_we;
    logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cfr_pkg::CFG_DATA_W-1:0] cfg_data;

    command_frame_receiver dut (.*);

    // Predictor copy of configuration and state
    int hdr1, hdr2, min_len, max_len, ctrl_id, set_id, timeout_ticks;
    int phase, flen, taken, exp_seq, link_ok, idle_cnt, mode_bits;
    logic [7:0] fstore [cfr_pkg::FRAME_BYTES];
    logic [7:0] cmd_now [cfr_pkg::CMD_BYTES];
    int bad_frames, seq_errs, reconnects;

    event_t pending_events[$];
    int errors;
    int cycles;
    bit jitter;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int sat16(int v);
        return (v < 65535) ? v + 1 : 65535;
    endfunction

    // Length byte at 0, frame bytes at 1..L, zero beyond
    function automatic int frame_byte(int pos);
        if (pos == 0)
            return flen;
        if (pos <= flen && pos <= cfr_pkg::FRAME_BYTES)
            return fstore[pos-1];
        return 0;
    endfunction

    function automatic event_t snapshot(logic [1:0] ev, logic se, logic rc);
        event_t r;
        r.ev = ev;
        r.seq_err = se;
        r.recon = rc;
        for (int i = 0; i < cfr_pkg::CMD_BYTES; i++)
            r.cmd[8*i +: 8] = cmd_now[i];
        r.mode = mode_bits[6:0];
        r.bad_cnt = bad_frames[15:0];
        r.seq_cnt = seq_errs[15:0];
        r.rec_cnt = reconnects[15:0];
        return r;
    endfunction

    function automatic void apply_records();
        int idx;
        int head;
        int rlen;
        idx = 2;
        while (idx + 1 < flen)
        begin
            head = frame_byte(idx);
            rlen = head & 'h0F;
            if (rlen == 0)
                rlen = 16;
            if ((head >> 4) == ctrl_id)
            begin
                for (int i = 0; i < cfr_pkg::CMD_BYTES; i++)
                    cmd_now[i] = 8'(frame_byte(idx + 1 + i));
            end
            else if ((head >> 4) == set_id)
                mode_bits = (frame_byte(idx + 1) >> 1) & 'h7F;
            idx += rlen + 1;
        end
    endfunction

    // Advance the predictor by one beat; return 1 with the event when one is due
    function automatic bit predict_beat(logic act, logic [7:0] b, output event_t r);
        int se, rc, ck1, ck2;
        r = '0;
        if (act == cfr_pkg::ACT_TICK)
        begin
            idle_cnt = sat16(idle_cnt);
            if (idle_cnt > timeout_ticks && link_ok)
            begin
                link_ok = 0;
                r = snapshot(cfr_pkg::EV_LOST, 1'b0, 1'b0);
                return 1;
            end
            return 0;
        end
        case (phase)
            0: if (b == hdr1) phase = 1;
            1: phase = (b == hdr2) ? 2 : 0;
            2:
            begin
                if (b > min_len && b < max_len && b <= cfr_pkg::FRAME_BYTES)
                begin
                    flen = b;
                    taken = 0;
                    phase = 3;
                end
                else
                    phase = 0;
            end
            default:
            begin
                if (taken < cfr_pkg::FRAME_BYTES)
                    fstore[taken] = b;
                taken = (taken + 1) & 'hFF;
                if (taken >= flen)
                begin
                    phase = 0;
                    se = 0;
                    rc = 0;
                    ck1 = 0;
                    ck2 = 0;
                    if (!link_ok)
                    begin
                        link_ok = 1;
                        reconnects = sat16(reconnects);
                        rc = 1;
                    end
                    idle_cnt = 0;
                    if (exp_seq != frame_byte(1))
                    begin
                        exp_seq = frame_byte(1);
                        seq_errs = sat16(seq_errs);
                        se = 1;
                    end
                    exp_seq = (exp_seq + 1) & 'hFF;
                    for (int p = 0; p + 1 < flen; p++)
                    begin
                        ck1 = (ck1 + frame_byte(p)) & 'hFF;
                        ck2 = (ck2 + ck1) & 'hFF;
                    end
                    if (frame_byte(flen - 1) == ck1 && frame_byte(flen) == ck2)
                    begin
                        apply_records();
                        r = snapshot(cfr_pkg::EV_GOOD, se[0], rc[0]);
                    end
                    else
                    begin
                        bad_frames = sat16(bad_frames);
                        r = snapshot(cfr_pkg::EV_BAD, se[0], rc[0]);
                    end
                    return 1;
                end
            end
        endcase
        return 0;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("ERROR %s: got %0h, want %0h", field, got, want);
        errors++;
    endtask

    // Send one beat and predict it once accepted; queues the event when one is due
    task automatic send_beat(logic act, logic [7:0] b, int typed_ev);
        event_t r;
        if (jitter && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= b;
        do
            @(posedge clk);
        while (!s_tready);
        if (predict_beat(act, b, r))
        begin
            if (typed_ev >= 0)
                r.ev = typed_ev[1:0];
            pending_events.push_back(r);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write one register; the caller drops cfg_we after the last write
    task automatic write_reg(logic [cfr_pkg::CFG_IDX_W-1:0] idx, int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[15:0];
        @(posedge clk);
        case (idx)
            cfr_pkg::REG_HEADER_FIRST:  hdr1 = value & 'hFF;
            cfr_pkg::REG_HEADER_SECOND: hdr2 = value & 'hFF;
            cfr_pkg::REG_MIN_LENGTH:    min_len = value & 'h3F;
            cfr_pkg::REG_MAX_LENGTH:    max_len = value & 'h7F;
            cfr_pkg::REG_CONTROL_ID:    ctrl_id = value & 'h0F;
            cfr_pkg::REG_SETTING_ID:    set_id = value & 'h0F;
            cfr_pkg::REG_LINK_TIMEOUT:  timeout_ticks = value & 'hFFFF;
            default: ;
        endcase
    endtask

    task automatic load_regs(int h1, int h2, int mn, int mx, int cid, int sid, int to);
        write_reg(cfr_pkg::REG_HEADER_FIRST, h1);
        write_reg(cfr_pkg::REG_HEADER_SECOND, h2);
        write_reg(cfr_pkg::REG_MIN_LENGTH, mn);
        write_reg(cfr_pkg::REG_MAX_LENGTH, mx);
        write_reg(cfr_pkg::REG_CONTROL_ID, cid);
        write_reg(cfr_pkg::REG_SETTING_ID, sid);
        write_reg(cfr_pkg::REG_LINK_TIMEOUT, to);
        cfg_we <= 1'b0;
    endtask

    // Send one framed command with random records, mostly with a good sum
    task automatic send_frame(ref int sent);
        logic [7:0] body [cfr_pkg::FRAME_BYTES];
        int lo, hi, len, idx, head, rlen, ck1, ck2, pick;
        lo = min_len + 1;
        hi = (max_len - 1 < cfr_pkg::FRAME_BYTES) ? max_len - 1 : cfr_pkg::FRAME_BYTES;
        if (lo > hi)
            len = $urandom_range(1, cfr_pkg::FRAME_BYTES);
        else if (hi > lo + 16 && $urandom_range(0, 7) != 0)
            len = $urandom_range(lo, lo + 16);
        else
            len = $urandom_range(lo, hi);
        for (int i = 0; i < cfr_pkg::FRAME_BYTES; i++)
            body[i] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 7)
            body[0] = exp_seq[7:0];
        idx = 2;
        while (idx + 1 < len)
        begin
            pick = $urandom_range(0, 9);
            head = (pick < 4) ? ctrl_id : (pick < 8) ? set_id : $urandom_range(0, 15);
            rlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(1, 6);
            body[idx-1] = 8'((head << 4) | rlen);
            idx += ((rlen == 0) ? 16 : rlen) + 1;
        end
        ck1 = 0;
        ck2 = 0;
        for (int p = 0; p + 1 < len; p++)
        begin
            ck1 = (ck1 + ((p == 0) ? len : body[p-1])) & 'hFF;
            ck2 = (ck2 + ck1) & 'hFF;
        end
        if (len >= 2)
        begin
            body[len-2] = ck1[7:0];
            body[len-1] = ck2[7:0];
        end
        // Corrupt a random byte now and then
        if ($urandom_range(0, 6) == 0)
            body[$urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
        send_beat(cfr_pkg::ACT_BYTE, hdr1[7:0], -1);
        send_beat(cfr_pkg::ACT_BYTE, hdr2[7:0], -1);
        send_beat(cfr_pkg::ACT_BYTE, len[7:0], -1);
        for (int i = 0; i < len; i++)
            send_beat(cfr_pkg::ACT_BYTE, body[i], -1);
        sent += len + 3;
    endtask

    task automatic run_random(int count);
        int sent, kind, n;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 3)
            begin
                // Tick run, long enough at times to lose the link
                n = $urandom_range(1, (timeout_ticks < 60) ? timeout_ticks + 3 : 60);
                repeat (n) send_beat(cfr_pkg::ACT_TICK, 8'($urandom_range(0, 255)), -1);
                sent += n;
            end
            else if (kind == 3)
            begin
                send_beat(cfr_pkg::ACT_BYTE, 8'($urandom_range(0, 255)), -1);
                sent++;
            end
            else if (kind == 4)
            begin
                // Broken start: header then a random second or length byte
                send_beat(cfr_pkg::ACT_BYTE, hdr1[7:0], -1);
                send_beat(cfr_pkg::ACT_BYTE, 8'($urandom_range(0, 255)), -1);
                send_beat(cfr_pkg::ACT_BYTE, 8'($urandom_range(0, 255)), -1);
                sent += 3;
            end
            else
                send_frame(sent);
        end
    endtask

    row_t dir_rows [22] = '{
        '{cfr_pkg::ACT_TICK, 8'h00, -1},
        '{cfr_pkg::ACT_BYTE, 8'h00, -1},
        '{cfr_pkg::ACT_BYTE, 8'hFF, -1},
        '{cfr_pkg::ACT_BYTE, 8'hAA, -1},              // length not above minimum
        '{cfr_pkg::ACT_BYTE, 8'h55, -1},
        '{cfr_pkg::ACT_BYTE, 8'h03, -1},
        '{cfr_pkg::ACT_BYTE, 8'hAA, -1},              // second header wrong
        '{cfr_pkg::ACT_BYTE, 8'h00, -1},
        '{cfr_pkg::ACT_BYTE, 8'hAA, -1},              // good frame, record runs past end
        '{cfr_pkg::ACT_BYTE, 8'h55, -1},
        '{cfr_pkg::ACT_BYTE, 8'h04, -1},
        '{cfr_pkg::ACT_BYTE, 8'h00, -1},
        '{cfr_pkg::ACT_BYTE, 8'h10, -1},
        '{cfr_pkg::ACT_BYTE, 8'h14, -1},
        '{cfr_pkg::ACT_BYTE, 8'h1C, cfr_pkg::EV_GOOD},
        '{cfr_pkg::ACT_BYTE, 8'hAA, -1},              // bad sum, wrong sequence
        '{cfr_pkg::ACT_BYTE, 8'h55, -1},
        '{cfr_pkg::ACT_BYTE, 8'h04, -1},
        '{cfr_pkg::ACT_BYTE, 8'h05, -1},
        '{cfr_pkg::ACT_BYTE, 8'h00, -1},
        '{cfr_pkg::ACT_BYTE, 8'h00, -1},
        '{cfr_pkg::ACT_BYTE, 8'h00, cfr_pkg::EV_BAD}
    };

    // Check each output beat against the oldest pending event
    always @(posedge clk)
    begin
        event_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_events.size() == 0)
                report("unexpected beat", m_tuser, 0);
            else
            begin
                want = pending_events.pop_front();
                if (m_tuser != want.ev)
                    report("event_res", m_tuser, want.ev);
                if (m_tdata[0] != want.seq_err)
                    report("sequence_error", m_tdata[0], want.seq_err);
                if (m_tdata[1] != want.recon)
                    report("reconnected", m_tdata[1], want.recon);
                if (m_tdata[41:2] != want.cmd)
                    report("commands", m_tdata[41:2], want.cmd);
                if (m_tdata[48:42] != want.mode)
                    report("report_mode_bits", m_tdata[48:42], want.mode);
                if (m_tdata[64:49] != want.bad_cnt)
                    report("bad_frame_count", m_tdata[64:49], want.bad_cnt);
                if (m_tdata[80:65] != want.seq_cnt)
                    report("sequence_error_count", m_tdata[80:65], want.seq_cnt);
                if (m_tdata[96:81] != want.rec_cnt)
                    report("reconnect_count", m_tdata[96:81], want.rec_cnt);
            end
        end
        // Stall the output in short bursts
        m_tready <= !(jitter && $urandom_range(0, 5) == 0);
    end

    // Watchdog on the whole run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("command_frame_receiver: mismatch");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        jitter = 1'b1;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hdr1 = 170; hdr2 = 85; min_len = 3; max_len = 64;
        ctrl_id = 1; set_id = 2; timeout_ticks = 100;
        phase = 0; flen = 0; taken = 0; exp_seq = 0; link_ok = 0; idle_cnt = 0;
        mode_bits = 0; bad_frames = 0; seq_errs = 0; reconnects = 0;
        cmd_now = '{8'd1, 8'd0, 8'd0, 8'd1, 8'd1};
        foreach (fstore[i]) fstore[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].act, dir_rows[i].val, dir_rows[i].ev);
        run_random(150);

        // Extremes: inverted headers, shortest frames, timeout of one tick
        wait_drained();
        load_regs(255, 0, 2, 4, 0, 15, 1);
        run_random(150);

        // No length passes; link never times out
        wait_drained();
        load_regs(0, 255, 63, 64, 15, 0, 65535);
        run_random(60);

        // Equal record ids act as control records
        wait_drained();
        load_regs(170, 85, 2, 64, 5, 5, 20);
        run_random(170);

        // Random headers and ids, last stretch without idling
        wait_drained();
        load_regs($urandom_range(0, 255), $urandom_range(0, 255), 3, 40,
                  $urandom_range(0, 15), $urandom_range(0, 15), 40);
        run_random(130);
        jitter = 1'b0;
        run_random(130);

        wait_drained();
        if (errors == 0)
            $display("command_frame_receiver: match");
        else
            $display("command_frame_receiver: mismatch");
        $finish;
    end

endmodule

// ===== command_frame_receiver.f =====
rtl/cfr_pkg.sv
rtl/cfr_front.sv
rtl/cfr_queue.sv
rtl/cfr_back.sv
rtl/command_frame_receiver.sv
verif/tb_top.sv
